FILE: sv/tcce_pkg.sv
package tcce_pkg;

  // default geometry limits
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 128;
  localparam int DEF_TAB_STOP = 4;

  // cell size as shift amounts: 8 x 16 pixels
  localparam int CELL_W_SHIFT = 3;
  localparam int CELL_H_SHIFT = 4;

  localparam logic [23:0] FG_RESET   = 24'hCDD6F4;
  localparam logic [23:0] BG_RESET   = 24'h1E1E2E;
  localparam logic [8:0]  COLS_RESET = 9'd128;
  localparam logic [7:0]  ROWS_RESET = 8'd48;

  localparam logic [7:0] CHAR_BS     = 8'd8;
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_NL     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] GLYPH_SPACE = 8'd32;

  typedef enum logic [1:0] {
    REG_FG_COLOR,
    REG_BG_COLOR,
    REG_COLUMN_COUNT,
    REG_ROW_COUNT
  } tcce_reg_t;

  typedef struct packed {
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [8:0]  column_count;
    logic [7:0]  row_count;
  } tcce_cfg_t;

  typedef struct packed {
    logic        draw_valid;
    logic [10:0] draw_x;
    logic [10:0] draw_y;
    logic [7:0]  draw_glyph;
    logic [23:0] draw_fg;
    logic [23:0] draw_bg;
    logic [7:0]  cursor_col;
    logic [6:0]  cursor_row;
  } tcce_result_t;

endpackage

FILE: sv/text_console_cursor_engine.sv
// Text console cursor engine: takes one character byte per item and returns
// one result item with the glyph draw command (pixel position in 8x16 cells,
// glyph and colors) and the cursor position after that character. Newline,
// return and tab move the cursor without drawing; backspace steps back and
// draws a space; every other byte draws itself and advances. The cursor wraps
// to the next row past the last column and to 0,0 past the last row. Items
// flow at one per cycle while result_ready is not held low; an accepted item
// passes the input register, then the result register. The rate is set
// by the cursor update, a single pass of short logic around the column/row
// registers each cycle. char_ready stays high while the input register is
// empty, or the result register is free or is being taken in the same cycle.
// Configuration writes take effect on the next cycle and must be made while
// no item is in flight.
module text_console_cursor_engine #(
  parameter int MAX_COLS = tcce_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcce_pkg::DEF_MAX_ROWS,
  parameter int TAB_STOP = tcce_pkg::DEF_TAB_STOP
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // character items
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_code,
  // result items
  output logic        result_valid,
  input  logic        result_ready,
  output logic        draw_valid,
  output logic [10:0] draw_x,
  output logic [10:0] draw_y,
  output logic [7:0]  draw_glyph,
  output logic [23:0] draw_fg,
  output logic [23:0] draw_bg,
  output logic [7:0]  cursor_col,
  output logic [6:0]  cursor_row
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PW = $clog2(TAB_STOP);

  tcce_pkg::tcce_cfg_t    cfg;
  tcce_pkg::tcce_result_t step_res;
  tcce_pkg::tcce_result_t res;

  // input register
  logic          st_valid;
  logic [7:0]    st_char;

  // cursor state; tab_phase tracks col_pos mod TAB_STOP so tab needs no divide
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [PW-1:0] tab_phase;
  logic [CW-1:0] col_pos_next;
  logic [RW-1:0] row_pos_next;
  logic [PW-1:0] tab_phase_next;

  logic          advance;

  // the input stage moves on whenever the result register is empty or drains
  assign advance    = !result_valid || result_ready;
  assign char_ready = !st_valid || advance;

  tcce_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  tcce_step #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_step (
    .char_code  (st_char),
    .col        (col_pos),
    .row        (row_pos),
    .phase      (tab_phase),
    .cfg        (cfg),
    .col_next   (col_pos_next),
    .row_next   (row_pos_next),
    .phase_next (tab_phase_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid     <= 1'b0;
      result_valid <= 1'b0;
      col_pos      <= '0;
      row_pos      <= '0;
      tab_phase    <= '0;
    end else begin
      if (char_ready) begin
        st_valid <= char_valid;
      end
      if (advance) begin
        result_valid <= st_valid;
      end
      // cursor commits as the item leaves the input register
      if (st_valid && advance) begin
        col_pos   <= col_pos_next;
        row_pos   <= row_pos_next;
        tab_phase <= tab_phase_next;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      st_char <= char_code;
    end
    if (st_valid && advance) begin
      res <= step_res;
    end
  end

  assign draw_valid = res.draw_valid;
  assign draw_x     = res.draw_x;
  assign draw_y     = res.draw_y;
  assign draw_glyph = res.draw_glyph;
  assign draw_fg    = res.draw_fg;
  assign draw_bg    = res.draw_bg;
  assign cursor_col = res.cursor_col;
  assign cursor_row = res.cursor_row;

`ifndef NO_ASSERTIONS
  // reset homes the cursor
  a_reset_home: assert property (@(posedge clk)
    rst |=> (col_pos == '0 && row_pos == '0 && tab_phase == '0))
    else $error("cursor not at home after reset");

  // a stalled output keeps the cursor from moving
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      ($stable(col_pos) && $stable(row_pos) && $stable(tab_phase)))
    else $error("cursor moved while result stalled");

  // an accepted item lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready) |=> st_valid)
    else $error("accepted item lost");

  // a result with no draw carries zero draw fields
  a_no_draw_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !draw_valid) |->
      (draw_x == '0 && draw_y == '0 && draw_glyph == '0 &&
       draw_fg == '0 && draw_bg == '0))
    else $error("draw fields set without a draw");
`endif

endmodule

FILE: sv/tcce_cfg_regs.sv
module tcce_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          index,
  input  logic [23:0]         data,
  output tcce_pkg::tcce_cfg_t cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color     <= tcce_pkg::FG_RESET;
      cfg.bg_color     <= tcce_pkg::BG_RESET;
      cfg.column_count <= tcce_pkg::COLS_RESET;
      cfg.row_count    <= tcce_pkg::ROWS_RESET;
    end else if (wr_en) begin
      unique case (tcce_pkg::tcce_reg_t'(index))
        tcce_pkg::REG_FG_COLOR:     cfg.fg_color     <= data;
        tcce_pkg::REG_BG_COLOR:     cfg.bg_color     <= data;
        tcce_pkg::REG_COLUMN_COUNT: cfg.column_count <= data[8:0];
        tcce_pkg::REG_ROW_COUNT:    cfg.row_count    <= data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/tcce_step.sv
module tcce_step #(
  parameter int MAX_COLS = tcce_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tcce_pkg::DEF_MAX_ROWS,
  parameter int TAB_STOP = tcce_pkg::DEF_TAB_STOP,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int PW = $clog2(TAB_STOP)
) (
  input  logic [7:0]             char_code,
  input  logic [CW-1:0]          col,
  input  logic [RW-1:0]          row,
  input  logic [PW-1:0]          phase,
  input  tcce_pkg::tcce_cfg_t    cfg,
  output logic [CW-1:0]          col_next,
  output logic [RW-1:0]          row_next,
  output logic [PW-1:0]          phase_next,
  output tcce_pkg::tcce_result_t res
);

  localparam int CMPW  = (CW + 5 > 11) ? CW + 5 : 11;
  localparam int RMPW  = (RW + 1 > 10) ? RW + 1 : 10;
  localparam int XFW   = (CW + 3 > 11) ? CW + 3 : 11;
  localparam int YFW   = (RW + 4 > 11) ? RW + 4 : 11;
  localparam int COW   = (CW > 8) ? CW : 8;
  localparam int ROW_W = (RW > 7) ? RW : 7;

  logic [CMPW-1:0]  cols;
  logic [CMPW-1:0]  ci;
  logic [RMPW-1:0]  rows;
  logic [RMPW-1:0]  ri;
  logic [PW-1:0]    ph;
  logic [CW-1:0]    dcol;
  logic             draw;
  logic [7:0]       glyph;
  logic [XFW-1:0]   x_full;
  logic [YFW-1:0]   y_full;
  logic [COW-1:0]   col_full;
  logic [ROW_W-1:0] row_full;

  always_comb begin
    // effective screen size: zero acts as one, oversize clips to the limit
    cols = CMPW'(cfg.column_count);
    if (cols == '0) begin
      cols = CMPW'(1);
    end else if (cols > CMPW'(MAX_COLS)) begin
      cols = CMPW'(MAX_COLS);
    end
    rows = RMPW'(cfg.row_count);
    if (rows == '0) begin
      rows = RMPW'(1);
    end else if (rows > RMPW'(MAX_ROWS)) begin
      rows = RMPW'(MAX_ROWS);
    end

    ci    = CMPW'(col);
    ri    = RMPW'(row);
    ph    = phase;
    dcol  = col;
    draw  = 1'b0;
    glyph = '0;

    unique case (char_code)
      tcce_pkg::CHAR_NL: begin
        ci = '0;
        ri = ri + RMPW'(1);
        ph = '0;
      end
      tcce_pkg::CHAR_CR: begin
        ci = '0;
        ph = '0;
      end
      tcce_pkg::CHAR_TAB: begin
        // phase holds col mod TAB_STOP, so the next stop is col + (stop - phase)
        ci = ci + CMPW'(TAB_STOP) - CMPW'(phase);
        ph = '0;
      end
      tcce_pkg::CHAR_BS: begin
        if (col != '0) begin
          ci   = ci - CMPW'(1);
          dcol = col - CW'(1);
          ph   = (phase == '0) ? PW'(TAB_STOP - 1) : phase - PW'(1);
        end
        draw  = 1'b1;
        glyph = tcce_pkg::GLYPH_SPACE;
      end
      default: begin
        draw  = 1'b1;
        glyph = char_code;
        ci    = ci + CMPW'(1);
        ph    = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + PW'(1);
      end
    endcase

    if (ci >= cols) begin
      ci = '0;
      ri = ri + RMPW'(1);
      ph = '0;
    end
    if (ri >= rows) begin
      ci = '0;
      ri = '0;
      ph = '0;
    end
  end

  assign col_next   = ci[CW-1:0];
  assign row_next   = ri[RW-1:0];
  assign phase_next = ph;

  assign x_full   = XFW'(dcol) << tcce_pkg::CELL_W_SHIFT;
  assign y_full   = YFW'(row) << tcce_pkg::CELL_H_SHIFT;
  assign col_full = COW'(ci[CW-1:0]);
  assign row_full = ROW_W'(ri[RW-1:0]);

  always_comb begin
    res.draw_valid = draw;
    res.draw_x     = draw ? x_full[10:0] : '0;
    res.draw_y     = draw ? y_full[10:0] : '0;
    res.draw_glyph = glyph;
    res.draw_fg    = draw ? cfg.fg_color : '0;
    res.draw_bg    = draw ? cfg.bg_color : '0;
    res.cursor_col = col_full[7:0];
    res.cursor_row = row_full[6:0];
  end

endmodule
